// ----- rtl/ajb_pkg.sv -----
// Package for the audio jitter buffer playback core: codes, reset values,
// reciprocal constants for the divide-by-100 steps, shared types.
// No dependencies.
`default_nettype none

package ajb_pkg;

	// Storage size default, in bytes
	localparam int RING_BYTES_DEF = 65536;

	// Input function codes
	localparam logic [1:0] FUNC_PUSH   = 2'd0;
	localparam logic [1:0] FUNC_PULL   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [1:0] FUNC_FINISH = 2'd3;

	// Configuration register indexes
	localparam int         CFG_IDX_W     = 2;
	localparam int         CFG_DATA_W    = 16;
	localparam logic [1:0] CFG_VOLUME    = 2'd0;
	localparam logic [1:0] CFG_CEILING   = 2'd1;
	localparam logic [1:0] CFG_PREROLL   = 2'd2;

	// Configuration reset values
	localparam logic [6:0]  VOLUME_RST  = 7'd50;
	localparam logic [6:0]  CEILING_RST = 7'd43;
	localparam logic [15:0] PREROLL_RST = 16'd19200;

	localparam logic [6:0] FULL_PERCENT = 7'd100;

	// floor(x/100) == (x * RECIP) >> SHIFT, exact over the operand ranges used:
	// gain operand <= 10000, sample product magnitude < 2^22
	localparam logic [13:0] GAIN_RECIP = 14'd10486;
	localparam int          GAIN_SHIFT = 20;
	localparam logic [22:0] DIV_RECIP  = 23'd5368710;
	localparam int          DIV_SHIFT  = 29;

	localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_IDX_W = 1;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_PULL   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_FINISH = 2'd3
	} ajb_op_t;

	typedef struct packed {
		ajb_op_t    op;
		logic [7:0] data_byte;
	} ajb_cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LO,
		BK_HI,
		BK_PROD,
		BK_DIV,
		BK_DONE
	} ajb_bk_state_t;

	typedef struct packed {
		logic               accepted;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic               playing;
		logic [15:0]        fill_bytes;
		logic               empty_res;
	} ajb_res_t;

endpackage

`default_nettype wire

// ----- rtl/ajb_if.sv -----
// Channel interfaces of the audio jitter buffer playback core: input items
// and result items, each with valid/ready. No dependencies.
`default_nettype none

interface ajb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;

	modport source(output valid, func, data_byte, input ready);
	modport sink(input valid, func, data_byte, output ready);
endinterface

interface ajb_out_if;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic               playing;
	logic [15:0]        fill_bytes;
	logic               empty_res;

	modport source(output valid, accepted, left_sample, right_sample, playing,
		fill_bytes, empty_res, input ready);
	modport sink(input valid, accepted, left_sample, right_sample, playing,
		fill_bytes, empty_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/audio_jitter_buffer_playback_core.sv -----
// Audio jitter buffer playback core. An accepted item is registered in the
// front-end queue, its result in the back end; a sample pull goes through
// BK_LO, BK_HI, BK_PROD, BK_DIV and BK_DONE first. Throughput: one push,
// clear, finish or silent pull per cycle while the back end is idle and its
// result slot is free; a sample pull holds the back end in those states, set
// by the byte-wide ring RAM read port (two reads) and the gain multiply and
// divide-by-100 steps. Reset clears pointers, flags and result slot, loads
// register defaults; the ring RAM is not cleared and no clearing pass runs.
`default_nettype none

module audio_jitter_buffer_playback_core #(
	parameter int RING_BYTES = ajb_pkg::RING_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	ajb_in_if.sink                              in_ch,
	ajb_out_if.source                           out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [ajb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ajb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// Pointer and RAM address width
	localparam int AW = $clog2(RING_BYTES);

	// Front to back command queue handshake
	logic              cmd_valid;
	logic              cmd_ready;
	ajb_pkg::ajb_cmd_t cmd;

	// Ring RAM port
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// Accept items and decode them; the two-entry queue lets the input side
	// keep moving while the back end works through a sample pull.
	ajb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in_ch),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Execute commands: pointer bookkeeping, pre-roll and finish flags,
	// sample read and scaling, result register toward the output channel.
	ajb_back #(
		.RING_BYTES (RING_BYTES),
		.AW         (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out       (out_ch)
	);

	// Byte store of the ring; only bytes that have been written are used
	ajb_ram #(
		.WIDTH (8),
		.DEPTH (RING_BYTES)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

// ----- rtl/ajb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ajb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/ajb_front.sv -----
// Front end: accept input items, decode the function code and hold the
// commands in a two-entry queue. Depends on ajb_pkg and ajb_if.
`default_nettype none

module ajb_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	ajb_in_if.sink                in,
	output      logic             cmd_valid,
	input  wire logic             cmd_ready,
	output      ajb_pkg::ajb_cmd_t cmd
);

	localparam int QD = ajb_pkg::QUEUE_DEPTH;
	localparam int QW = ajb_pkg::QUEUE_IDX_W;

	ajb_pkg::ajb_cmd_t entries_q [QD];
	logic [QW-1:0]     wr_ptr_q;
	logic [QW-1:0]     rd_ptr_q;
	logic [QW:0]       count_q;
	ajb_pkg::ajb_cmd_t decoded;
	logic              push;
	logic              pop;

	// Decode the function code
	always_comb begin
		decoded.data_byte = in.data_byte;
		case (in.func)
			ajb_pkg::FUNC_PUSH:   decoded.op = ajb_pkg::OP_PUSH;
			ajb_pkg::FUNC_PULL:   decoded.op = ajb_pkg::OP_PULL;
			ajb_pkg::FUNC_CLEAR:  decoded.op = ajb_pkg::OP_CLEAR;
			ajb_pkg::FUNC_FINISH: decoded.op = ajb_pkg::OP_FINISH;
			default:              decoded.op = ajb_pkg::OP_PUSH;
		endcase
	end

	assign in.ready  = (count_q != (QW+1)'(QD));
	assign push      = in.valid && in.ready;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QW'(QD-1)) ? '0 : wr_ptr_q + QW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QW'(QD-1)) ? '0 : rd_ptr_q + QW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ajb_back.sv -----
// Back end: carry out queued commands against the ring pointers and flags,
// read pulled samples from the ring RAM, scale them and register results.
// Depends on ajb_pkg and ajb_if.
`default_nettype none

module ajb_back #(
	parameter int RING_BYTES = ajb_pkg::RING_BYTES_DEF,
	parameter int AW         = $clog2(RING_BYTES)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output      logic                           cmd_ready,
	input  wire ajb_pkg::ajb_cmd_t              cmd,
	input  wire logic                           cfg_we,
	input  wire logic [ajb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ajb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output      logic                           ram_we,
	output      logic [AW-1:0]                  ram_waddr,
	output      logic [7:0]                     ram_wdata,
	output      logic [AW-1:0]                  ram_raddr,
	input  wire logic [7:0]                     ram_rdata,
	ajb_out_if.source                           out
);

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(RING_BYTES-1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] held_of(input logic [AW-1:0] w,
		input logic [AW-1:0] r);
		if (w >= r) begin
			return w - r;
		end
		return AW'({1'b0, w} + (AW+1)'(RING_BYTES) - {1'b0, r});
	endfunction

	ajb_pkg::ajb_bk_state_t state_q, state_d;
	logic [AW-1:0] rp_q, rp_d;
	logic [AW-1:0] wp_q, wp_d;
	logic          prerolled_q, prerolled_d;
	logic          finish_q, finish_d;
	logic [6:0]    volume_q;
	logic [6:0]    ceiling_q;
	logic [15:0]   preroll_q;

	// Pull datapath registers
	logic [7:0]         lo_q;
	logic [13:0]        vc_q;
	logic [15:0]        smp_q;
	logic [6:0]         gain_q;
	logic [21:0]        mag_q;
	logic               neg_q;
	logic [15:0]        quo_q;

	logic               out_valid_q;
	ajb_pkg::ajb_res_t  res_q, res_d;
	logic               res_load;
	logic               slot_free;

	logic [AW-1:0]      held;
	logic [AW-1:0]      held_new;
	logic [31:0]        held32;
	logic [31:0]        held_new32;
	logic               full;
	logic               play_now;
	logic [6:0]         cv;
	logic [6:0]         cc;
	logic [27:0]        gprod;
	logic signed [23:0] smp_x;
	logic signed [23:0] gain_x;
	logic signed [23:0] prod;
	logic [23:0]        mag_w;
	logic [44:0]        qprod;
	logic signed [16:0] rval;
	logic signed [15:0] sat_w;

	assign held      = held_of(wp_q, rp_q);
	assign held32    = 32'(held);
	assign full      = (held == AW'(RING_BYTES-1));
	assign play_now  = prerolled_q || finish_q || (held32 >= 32'(preroll_q));
	assign slot_free = !out_valid_q || out.ready;

	assign cv = (volume_q > ajb_pkg::FULL_PERCENT) ? ajb_pkg::FULL_PERCENT : volume_q;
	assign cc = (ceiling_q > ajb_pkg::FULL_PERCENT) ? ajb_pkg::FULL_PERCENT : ceiling_q;

	assign gprod  = 28'(vc_q) * 28'(ajb_pkg::GAIN_RECIP);
	assign smp_x  = {{8{smp_q[15]}}, smp_q};
	assign gain_x = {17'd0, gain_q};
	assign prod   = smp_x * gain_x;
	assign mag_w  = prod[23] ? 24'(-prod) : 24'(prod);
	assign qprod  = 45'(mag_q) * 45'(ajb_pkg::DIV_RECIP);
	assign rval   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_comb begin
		if (rval > 17'(ajb_pkg::SAMPLE_MAX)) begin
			sat_w = ajb_pkg::SAMPLE_MAX;
		end else if (rval < 17'(ajb_pkg::SAMPLE_MIN)) begin
			sat_w = ajb_pkg::SAMPLE_MIN;
		end else begin
			sat_w = rval[15:0];
		end
	end

	// Sequencer: next state, pointer and flag updates, result assembly
	always_comb begin
		state_d     = state_q;
		rp_d        = rp_q;
		wp_d        = wp_q;
		prerolled_d = prerolled_q;
		finish_d    = finish_q;
		cmd_ready   = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = wp_q;
		ram_wdata   = cmd.data_byte;
		ram_raddr   = rp_q;
		res_load    = 1'b0;
		res_d       = '0;
		case (state_q)
			ajb_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						ajb_pkg::OP_PUSH: begin
							if (slot_free) begin
								cmd_ready = 1'b1;
								res_load  = 1'b1;
								res_d.playing = prerolled_q || finish_q;
								if (!full) begin
									ram_we = 1'b1;
									wp_d   = wrap_inc(wp_q);
									res_d.accepted = 1'b1;
								end
							end
						end
						ajb_pkg::OP_PULL: begin
							if (play_now && (held32 >= 32'd2)) begin
								// Start the two-byte read; result comes in BK_DONE
								cmd_ready   = 1'b1;
								prerolled_d = prerolled_q || !finish_q;
								state_d     = ajb_pkg::BK_LO;
							end else if (slot_free) begin
								cmd_ready = 1'b1;
								res_load  = 1'b1;
								res_d.playing = play_now;
								if (play_now) begin
									prerolled_d = prerolled_q || !finish_q;
								end
							end
						end
						ajb_pkg::OP_CLEAR: begin
							if (slot_free) begin
								cmd_ready   = 1'b1;
								res_load    = 1'b1;
								rp_d        = '0;
								wp_d        = '0;
								prerolled_d = 1'b0;
								finish_d    = 1'b0;
								res_d.accepted = 1'b1;
							end
						end
						ajb_pkg::OP_FINISH: begin
							if (slot_free) begin
								cmd_ready = 1'b1;
								res_load  = 1'b1;
								finish_d  = 1'b1;
								res_d.accepted = 1'b1;
								res_d.playing  = 1'b1;
							end
						end
						default: begin
							cmd_ready = 1'b0;
						end
					endcase
				end
			end
			ajb_pkg::BK_LO: begin
				ram_raddr = wrap_inc(rp_q);
				state_d   = ajb_pkg::BK_HI;
			end
			ajb_pkg::BK_HI: begin
				state_d = ajb_pkg::BK_PROD;
			end
			ajb_pkg::BK_PROD: begin
				state_d = ajb_pkg::BK_DIV;
			end
			ajb_pkg::BK_DIV: begin
				state_d = ajb_pkg::BK_DONE;
			end
			ajb_pkg::BK_DONE: begin
				if (slot_free) begin
					res_load = 1'b1;
					rp_d     = wrap_inc(wrap_inc(rp_q));
					state_d  = ajb_pkg::BK_IDLE;
					res_d.accepted     = 1'b1;
					res_d.playing      = 1'b1;
					res_d.left_sample  = sat_w;
					res_d.right_sample = sat_w;
				end
			end
			default: begin
				state_d = ajb_pkg::BK_IDLE;
			end
		endcase
		held_new         = held_of(wp_d, rp_d);
		held_new32       = 32'(held_new);
		res_d.fill_bytes = held_new32[15:0];
		res_d.empty_res  = (held_new == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ajb_pkg::BK_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			prerolled_q <= 1'b0;
			finish_q    <= 1'b0;
			volume_q    <= ajb_pkg::VOLUME_RST;
			ceiling_q   <= ajb_pkg::CEILING_RST;
			preroll_q   <= ajb_pkg::PREROLL_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rp_q        <= rp_d;
			wp_q        <= wp_d;
			prerolled_q <= prerolled_d;
			finish_q    <= finish_d;
			if (cfg_we) begin
				case (cfg_index)
					ajb_pkg::CFG_VOLUME:  volume_q  <= cfg_wdata[6:0];
					ajb_pkg::CFG_CEILING: ceiling_q <= cfg_wdata[6:0];
					ajb_pkg::CFG_PREROLL: preroll_q <= cfg_wdata[15:0];
					default:              preroll_q <= preroll_q;
				endcase
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pull datapath: low byte, gain, product magnitude, divide by 100
	always_ff @(posedge clk) begin
		if (state_q == ajb_pkg::BK_LO) begin
			lo_q <= ram_rdata;
			vc_q <= 14'(cv) * 14'(cc);
		end
		if (state_q == ajb_pkg::BK_HI) begin
			smp_q  <= {ram_rdata, lo_q};
			gain_q <= 7'(gprod >> ajb_pkg::GAIN_SHIFT);
		end
		if (state_q == ajb_pkg::BK_PROD) begin
			neg_q <= prod[23];
			mag_q <= mag_w[21:0];
		end
		if (state_q == ajb_pkg::BK_DIV) begin
			quo_q <= 16'(qprod >> ajb_pkg::DIV_SHIFT);
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign out.valid        = out_valid_q;
	assign out.accepted     = res_q.accepted;
	assign out.left_sample  = res_q.left_sample;
	assign out.right_sample = res_q.right_sample;
	assign out.playing      = res_q.playing;
	assign out.fill_bytes   = res_q.fill_bytes;
	assign out.empty_res    = res_q.empty_res;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for the audio jitter buffer playback core: queues command items,
// predicts each result item from a local ring copy, and checks the results.
// Depends on ajb_pkg, the channel interfaces in ajb_if.sv and the core itself.

module testbench;
	import ajb_pkg::*;

	localparam int RING = RING_BYTES_DEF;
	// Long receiver hold-off for the back-pressure phase
	localparam int HOLD_CYCLES = 300;
	// Settle time after the last result
	localparam int SETTLE_CYCLES = 12;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ajb_in_if  cmd_ch();
	ajb_out_if res_ch();

	audio_jitter_buffer_playback_core #(
		.RING_BYTES(RING)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (cmd_ch),
		.out_ch   (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Local copy of the playback state: ring contents, pointers, flags, registers
	logic [7:0]  ring_copy [RING];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	logic        prerolled;
	logic        finish_pending;
	logic [6:0]  volume_cfg;
	logic [6:0]  ceiling_cfg;
	logic [15:0] preroll_cfg;

	// Command items waiting for the driver, and result items still owed by the core
	ajb_cmd_t cmd_queue[$];
	ajb_res_t expected_results[$];
	int       cmds_queued = 0;
	int       cmds_taken = 0;
	int       mismatch_count = 0;

	// Idle percentages per side, and the long receiver hold-off
	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_active = 1'b0;
	event hold_go;

	ajb_cmd_t next_cmd;
	ajb_cmd_t taken_cmd;
	ajb_res_t want;

	function automatic int unsigned bytes_held();
		return (wr_ptr + RING - rd_ptr) % RING;
	endfunction

	// Advance the local state by one command item and return its result item
	function automatic ajb_res_t predict_playback(ajb_cmd_t cmd);
		ajb_res_t    res;
		int unsigned held;
		logic [15:0] raw;
		int          pcm;
		int          vol_pct;
		int          ceil_pct;
		int          gain;
		int          scaled;

		res = '0;
		res.accepted = 1'b1;
		held = bytes_held();
		case (cmd.op)
			OP_PUSH: begin
				// Keep one slot free: a push at capacity minus one is dropped
				if (held < RING - 1) begin
					ring_copy[wr_ptr] = cmd.data_byte;
					wr_ptr = (wr_ptr + 1) % RING;
				end else begin
					res.accepted = 1'b0;
				end
				res.playing = prerolled | finish_pending;
			end
			OP_PULL: begin
				res.playing = 1'b1;
				// Hold silence until the pre-roll level, unless finish forces playback
				if (!prerolled && !finish_pending) begin
					if (held < preroll_cfg)
						res.playing = 1'b0;
					else
						prerolled = 1'b1;
				end
				if (!res.playing) begin
					res.accepted = 1'b0;
				end else if (held >= 2) begin
					raw = {ring_copy[(rd_ptr + 1) % RING], ring_copy[rd_ptr]};
					rd_ptr = (rd_ptr + 2) % RING;
					pcm = $signed(raw);
					vol_pct = (volume_cfg > FULL_PERCENT) ? FULL_PERCENT : volume_cfg;
					ceil_pct = (ceiling_cfg > FULL_PERCENT) ? FULL_PERCENT : ceiling_cfg;
					gain = (vol_pct * ceil_pct) / int'(FULL_PERCENT);
					// SV integer division truncates toward zero
					scaled = (pcm * gain) / int'(FULL_PERCENT);
					if (scaled > SAMPLE_MAX)
						scaled = SAMPLE_MAX;
					if (scaled < SAMPLE_MIN)
						scaled = SAMPLE_MIN;
					res.left_sample = scaled[15:0];
					res.right_sample = scaled[15:0];
				end else begin
					// A lone byte or an empty buffer: give silence, leave any lone byte in place
					res.accepted = 1'b0;
				end
			end
			OP_CLEAR: begin
				rd_ptr = 0;
				wr_ptr = 0;
				prerolled = 1'b0;
				finish_pending = 1'b0;
				res.playing = 1'b0;
			end
			default: begin
				finish_pending = 1'b1;
				res.playing = 1'b1;
			end
		endcase
		res.fill_bytes = 16'(bytes_held());
		res.empty_res = (bytes_held() == 0);
		return res;
	endfunction

	task automatic compare_field(string field, integer want_v, integer got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
			mismatch_count++;
		end
	endtask

	// Driver: predict on each accepted item, then offer the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.func <= FUNC_PUSH;
			cmd_ch.data_byte <= 8'h00;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				taken_cmd.op = ajb_op_t'(cmd_ch.func);
				taken_cmd.data_byte = cmd_ch.data_byte;
				expected_results.push_back(predict_playback(taken_cmd));
				cmds_taken++;
			end
			// Hold the current item while the core stalls; otherwise the slot is free
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_cmd = cmd_queue.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.func <= next_cmd.op;
					cmd_ch.data_byte <= next_cmd.data_byte;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result item, expected none, actual fill %0d",
						$time, res_ch.fill_bytes);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("accepted", want.accepted, res_ch.accepted);
					compare_field("left_sample", want.left_sample, res_ch.left_sample);
					compare_field("right_sample", want.right_sample, res_ch.right_sample);
					compare_field("playing", want.playing, res_ch.playing);
					compare_field("fill_bytes", want.fill_bytes, res_ch.fill_bytes);
					compare_field("empty_res", want.empty_res, res_ch.empty_res);
				end
			end
			res_ch.ready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off, counted here so the sender keeps offering items
	always begin
		@(hold_go);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	task automatic queue_cmd(ajb_op_t op, logic [7:0] data);
		ajb_cmd_t c;

		c.op = op;
		c.data_byte = data;
		cmd_queue.push_back(c);
		cmds_queued++;
	endtask

	// Mostly pushes and pulls so playback gets going; finish and clear now and then
	task automatic queue_random_cmds(int count);
		int roll;

		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 60)
				queue_cmd(OP_PUSH, 8'($urandom_range(0, 255)));
			else if (roll < 95)
				queue_cmd(OP_PULL, 8'($urandom_range(0, 255)));
			else if (roll < 98)
				queue_cmd(OP_FINISH, 8'($urandom_range(0, 255)));
			else
				queue_cmd(OP_CLEAR, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct <= send_pct;
		recv_stall_pct <= recv_pct;
	endtask

	// Wait until every queued item has been taken and every result has come back
	task automatic wait_quiet();
		while (cmds_taken != cmds_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write, only while the core is idle; mirror it in the local copy
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_VOLUME:  volume_cfg = value[6:0];
			CFG_CEILING: ceiling_cfg = value[6:0];
			CFG_PREROLL: preroll_cfg = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_VOLUME;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FUNC_PUSH;
		cmd_ch.data_byte = 8'h00;
		res_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		rd_ptr = 0;
		wr_ptr = 0;
		prerolled = 1'b0;
		finish_pending = 1'b0;
		volume_cfg = VOLUME_RST;
		ceiling_cfg = CEILING_RST;
		preroll_cfg = PREROLL_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: gain 21, pre-roll far out of reach, so only finish plays
		queue_cmd(OP_PULL, 8'hA5);
		queue_cmd(OP_PUSH, 8'h00);
		queue_cmd(OP_PUSH, 8'h80);
		queue_cmd(OP_FINISH, 8'h00);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_PULL, 8'hFF);
		queue_cmd(OP_PUSH, 8'hFF);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_PUSH, 8'h7F);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_CLEAR, 8'h00);
		queue_cmd(OP_PULL, 8'h00);
		wait_quiet();

		// Full gain and zero pre-roll: the first pull starts playback even when empty
		write_reg(CFG_VOLUME, 16'd100);
		write_reg(CFG_CEILING, 16'd100);
		write_reg(CFG_PREROLL, 16'd0);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_PUSH, 8'h01);
		queue_cmd(OP_PUSH, 8'h80);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_PUSH, 8'hFF);
		queue_cmd(OP_PUSH, 8'hFF);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_CLEAR, 8'h00);
		wait_quiet();

		// Small pre-roll: reach it exactly, then drain down to a lone byte
		write_reg(CFG_PREROLL, 16'd3);
		queue_cmd(OP_PUSH, 8'h34);
		queue_cmd(OP_PUSH, 8'h12);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_PUSH, 8'h56);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_FINISH, 8'h00);
		queue_cmd(OP_CLEAR, 8'h00);
		wait_quiet();

		// Random phases: a new register setting and idling pattern for each
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_reg(CFG_VOLUME, 16'd100);
					write_reg(CFG_CEILING, 16'd100);
					write_reg(CFG_PREROLL, 16'd0);
					set_idling(0, 0);
				end
				1: begin
					write_reg(CFG_VOLUME, 16'd0);
					write_reg(CFG_CEILING, 16'd43);
					write_reg(CFG_PREROLL, 16'd1);
					set_idling(61, 0);
				end
				2: begin
					// Out-of-range percentages saturate to full scale
					write_reg(CFG_VOLUME, 16'd127);
					write_reg(CFG_CEILING, 16'd127);
					write_reg(CFG_PREROLL, 16'($urandom_range(2, 24)));
					set_idling(0, 61);
				end
				default: begin
					// Upper data bits are junk for the 7-bit registers
					write_reg(CFG_VOLUME, 16'($urandom_range(0, 65535)));
					write_reg(CFG_CEILING, 16'($urandom_range(0, 65535)));
					write_reg(CFG_PREROLL, 16'($urandom_range(0, 24)));
					set_idling(29, 29);
				end
			endcase
			queue_cmd(OP_CLEAR, 8'h00);
			queue_random_cmds(230);
			wait_quiet();
		end

		// Back-pressure: hold the receiver off while the sender keeps offering items
		write_reg(CFG_VOLUME, 16'($urandom_range(0, 100)));
		write_reg(CFG_CEILING, 16'($urandom_range(0, 100)));
		write_reg(CFG_PREROLL, 16'd4);
		set_idling(0, 0);
		queue_random_cmds(80);
		-> hold_go;
		wait_quiet();

		// Largest pre-roll: pulls stay silent until a finish forces playback
		write_reg(CFG_VOLUME, 16'd100);
		write_reg(CFG_CEILING, 16'd100);
		write_reg(CFG_PREROLL, 16'd65535);
		queue_cmd(OP_CLEAR, 8'h00);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_PUSH, 8'h11);
		queue_cmd(OP_PUSH, 8'h22);
		queue_cmd(OP_PUSH, 8'h33);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_FINISH, 8'h00);
		queue_cmd(OP_PULL, 8'h00);
		queue_cmd(OP_PULL, 8'h00);
		queue_random_cmds(40);
		queue_cmd(OP_CLEAR, 8'h00);
		wait_quiet();

		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ajb_pkg.sv
rtl/ajb_if.sv
rtl/ajb_ram.sv
rtl/ajb_front.sv
rtl/ajb_back.sv
rtl/audio_jitter_buffer_playback_core.sv
verif/testbench.sv
